### src/l2lhp_pkg.sv
// Shared constants, types and helpers for the log2 latency histogram.
// Used by the bucket RAM, the percentile scanner and the top level.
package l2lhp_pkg;

    localparam int NUM_BUCKETS = 64;
    localparam int COUNT_BITS  = 32;
    localparam int IDX_BITS    = $clog2(NUM_BUCKETS);
    localparam int TOTAL_BITS  = COUNT_BITS + IDX_BITS;
    localparam int PM_BITS     = 10;
    localparam int PROD_BITS   = TOTAL_BITS + PM_BITS;
    localparam int LAT_BITS    = 64;
    localparam int POS_BITS    = 6;

    localparam logic [IDX_BITS-1:0]   LAST_IDX   = IDX_BITS'(NUM_BUCKETS - 1);
    localparam logic [POS_BITS-1:0]   LAST_POS   = POS_BITS'(NUM_BUCKETS - 1);
    localparam logic [POS_BITS:0]     SAT_POS    = 7'd63;
    localparam logic [COUNT_BITS-1:0] COUNT_MAX  = '1;
    localparam logic [PM_BITS-1:0]    PER_THOUSAND = 10'd1000;
    localparam logic [LAT_BITS-1:0]   BOUND_ALL_ONES = '1;
    localparam logic [LAT_BITS-1:0]   BOUND_EMPTY    = '0;

    typedef enum logic {
        ACT_RECORD = 1'b0,
        ACT_QUERY  = 1'b1
    } t_action;

    typedef struct packed {
        logic                en;
        logic [IDX_BITS-1:0] addr;
    } t_ram_rd;

    typedef struct packed {
        logic                  en;
        logic [IDX_BITS-1:0]   addr;
        logic [COUNT_BITS-1:0] data;
    } t_ram_wr;

    typedef struct packed {
        logic                done;
        logic [LAT_BITS-1:0] bound;
    } t_scan_res;

    // Position of the highest set bit, binary search in six halving steps.
    // Zero lands on position 0, same as a value of one.
    function automatic logic [POS_BITS-1:0] top_bit_pos(input logic [LAT_BITS-1:0] v);
        logic [LAT_BITS-1:0] x;
        logic [POS_BITS-1:0] p;
        x = v;
        p = '0;
        for (int s = POS_BITS - 1; s >= 0; s--) begin
            if ((x >> (1 << s)) != '0) begin
                x    = x >> (1 << s);
                p[s] = 1'b1;
            end
        end
        return p;
    endfunction

    function automatic logic [IDX_BITS-1:0] bucket_of(input logic [LAT_BITS-1:0] v);
        logic [POS_BITS-1:0] p;
        p = top_bit_pos(v);
        if (p > LAST_POS) begin
            p = LAST_POS;
        end
        return IDX_BITS'(p);
    endfunction

endpackage

### src/log2_latency_histogram_percentile.sv
// Top level of the log2 latency histogram: control FSM, running total and
// output register. Instantiates l2lhp_bucket_ram and l2lhp_scan; uses l2lhp_pkg.
//
// A record transaction reads the bucket counter from the counter RAM on
// acceptance and writes it back incremented (saturating) in the next cycle.
// A query transaction stalls further input until its result is loaded. The
// S_MUL state multiplies the running total by the per-mille value. Then one
// RAM read per bucket is streamed through a two-stage accumulate-and-compare
// pipeline, and S_HOLD loads the output register. The scan stops at the first
// bucket that reaches the threshold. On an empty histogram a query skips the
// scan. A finished query waits for as long as the previous result is stalled
// at the output. The result sits in an output register, so records keep
// flowing while it waits.
// Counters start at zero after reset with no clearing pass.
module log2_latency_histogram_percentile import l2lhp_pkg::*; (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_stall,
    input  logic                i_action,
    input  logic [LAT_BITS-1:0] i_elapsed_us,
    input  logic [PM_BITS-1:0]  i_per_mille,
    output logic                o_out_valid,
    input  logic                i_out_stall,
    output logic [LAT_BITS-1:0] o_percentile_bound
);

    typedef enum logic [4:0] {
        S_IDLE = 5'b00001,
        S_REC  = 5'b00010,
        S_MUL  = 5'b00100,
        S_SCAN = 5'b01000,
        S_HOLD = 5'b10000
    } t_state;

    t_state                r_state;
    logic [IDX_BITS-1:0]   r_rec_idx;
    logic [TOTAL_BITS-1:0] r_total;
    logic [PM_BITS-1:0]    r_pm;
    logic [PROD_BITS-1:0]  r_prod;
    logic [LAT_BITS-1:0]   r_res;
    logic                  r_out_valid;
    logic [LAT_BITS-1:0]   r_out_bound;

    logic                  in_accept;
    logic                  out_free;
    logic                  scan_start;
    logic                  not_full;
    logic [COUNT_BITS-1:0] rd_data;
    t_ram_rd               ram_rd;
    t_ram_rd               scan_rd;
    t_ram_wr               ram_wr;
    t_scan_res             scan_res;

    assign o_in_stall = (r_state != S_IDLE);
    assign in_accept  = i_in_valid && !o_in_stall;
    assign out_free   = !r_out_valid || !i_out_stall;
    assign scan_start = (r_state == S_MUL) && (r_total != '0);
    assign not_full   = (rd_data != COUNT_MAX);

    always_comb begin
        if (r_state == S_SCAN) begin
            ram_rd = scan_rd;
        end else begin
            ram_rd.en   = in_accept && (i_action == ACT_RECORD);
            ram_rd.addr = bucket_of(i_elapsed_us);
        end
        ram_wr.en   = (r_state == S_REC);
        ram_wr.addr = r_rec_idx;
        ram_wr.data = rd_data + COUNT_BITS'(not_full);
    end

    l2lhp_bucket_ram u_ram (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_rd      (ram_rd),
        .i_wr      (ram_wr),
        .o_rd_data (rd_data)
    );

    l2lhp_scan u_scan (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_start   (scan_start),
        .i_prod    (r_prod),
        .i_rd_data (rd_data),
        .o_rd      (scan_rd),
        .o_res     (scan_res)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_total     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (r_state == S_HOLD && out_free) begin
                r_out_valid <= 1'b1;
            end else if (r_out_valid && !i_out_stall) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (in_accept) begin
                        r_state <= (i_action == ACT_QUERY) ? S_MUL : S_REC;
                    end
                end
                S_REC: begin
                    r_total <= r_total + TOTAL_BITS'(not_full);
                    r_state <= S_IDLE;
                end
                S_MUL: begin
                    r_state <= (r_total == '0) ? S_HOLD : S_SCAN;
                end
                S_SCAN: begin
                    if (scan_res.done) begin
                        r_state <= S_HOLD;
                    end
                end
                S_HOLD: begin
                    if (out_free) begin
                        r_state <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_rec_idx <= bucket_of(i_elapsed_us);
            r_pm      <= i_per_mille;
        end
        if (r_state == S_MUL) begin
            r_prod <= PROD_BITS'(r_total) * PROD_BITS'(r_pm);
            r_res  <= BOUND_EMPTY;
        end
        if (r_state == S_SCAN && scan_res.done) begin
            r_res <= scan_res.bound;
        end
        if (r_state == S_HOLD && out_free) begin
            r_out_bound <= r_res;
        end
    end

    assign o_out_valid        = r_out_valid;
    assign o_percentile_bound = r_out_bound;

`ifndef SYNTHESIS
    a_scan_done_in_scan: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        scan_res.done |-> (r_state == S_SCAN))
        else $error("scan finished outside of a query");

    a_record_writes_back: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_accept && (i_action == ACT_RECORD)) |=> ram_wr.en)
        else $error("record transaction without counter write-back");

    a_result_from_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> $past(r_state == S_HOLD))
        else $error("result presented without a finished query");
`endif

endmodule

### src/l2lhp_bucket_ram.sv
// Bucket counter RAM: one write port, one read port, registered read data.
// Per-entry valid bits make unwritten entries read as zero after reset. Uses l2lhp_pkg.
module l2lhp_bucket_ram import l2lhp_pkg::*; (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  t_ram_rd               i_rd,
    input  t_ram_wr               i_wr,
    output logic [COUNT_BITS-1:0] o_rd_data
);

    logic [COUNT_BITS-1:0]  r_mem [NUM_BUCKETS];
    logic [NUM_BUCKETS-1:0] r_valid;
    logic [COUNT_BITS-1:0]  r_rd_raw;
    logic                   r_rd_vld;

    always_ff @(posedge i_clk) begin
        if (i_wr.en) begin
            r_mem[i_wr.addr] <= i_wr.data;
        end
        if (i_rd.en) begin
            r_rd_raw <= r_mem[i_rd.addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid  <= '0;
            r_rd_vld <= 1'b0;
        end else begin
            if (i_wr.en) begin
                r_valid[i_wr.addr] <= 1'b1;
            end
            if (i_rd.en) begin
                r_rd_vld <= r_valid[i_rd.addr];
            end
        end
    end

    assign o_rd_data = r_rd_vld ? r_rd_raw : '0;

endmodule

### src/l2lhp_scan.sv
// Percentile scanner: streams the bucket RAM from index 0, accumulates counts
// and finds the first bucket with seen*1000 >= total*per_mille. Uses l2lhp_pkg.
module l2lhp_scan import l2lhp_pkg::*; (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_start,
    input  logic [PROD_BITS-1:0]  i_prod,
    input  logic [COUNT_BITS-1:0] i_rd_data,
    output t_ram_rd               o_rd,
    output t_scan_res             o_res
);

    logic                  r_issue;
    logic [IDX_BITS-1:0]   r_addr;
    logic                  r_dv;
    logic [IDX_BITS-1:0]   r_dv_idx;
    logic                  r_chk;
    logic [IDX_BITS-1:0]   r_chk_idx;
    logic [TOTAL_BITS-1:0] r_seen;
    logic [PROD_BITS-1:0]  seen_k;
    logic                  hit;
    logic                  done;

    // seen >= ceil(prod/1000) is the same as seen*1000 >= prod for integers
    assign seen_k = PROD_BITS'(r_seen) * PROD_BITS'(PER_THOUSAND);
    assign hit    = seen_k >= i_prod;
    assign done   = r_chk && (hit || r_chk_idx == LAST_IDX);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_issue <= 1'b0;
            r_dv    <= 1'b0;
            r_chk   <= 1'b0;
            r_addr  <= '0;
        end else if (done) begin
            r_issue <= 1'b0;
            r_dv    <= 1'b0;
            r_chk   <= 1'b0;
        end else begin
            if (i_start) begin
                r_issue <= 1'b1;
                r_addr  <= '0;
            end else if (r_issue) begin
                r_addr <= r_addr + 1'b1;
                if (r_addr == LAST_IDX) begin
                    r_issue <= 1'b0;
                end
            end
            r_dv  <= r_issue;
            r_chk <= r_dv;
        end
    end

    always_ff @(posedge i_clk) begin
        r_dv_idx <= r_addr;
        if (i_start) begin
            r_seen <= '0;
        end else if (r_dv) begin
            r_seen    <= r_seen + TOTAL_BITS'(i_rd_data);
            r_chk_idx <= r_dv_idx;
        end
    end

    always_comb begin
        o_rd.en     = r_issue;
        o_rd.addr   = r_addr;
        o_res.done  = done;
        o_res.bound = BOUND_ALL_ONES;
        if (hit && ((POS_BITS + 1)'(r_chk_idx) < SAT_POS)) begin
            o_res.bound = LAT_BITS'(1) << r_chk_idx;
        end
    end

endmodule
